/* rtl/wdr_pkg.sv */
// Package with shared types, widths and constants of the waveguide delay resonator.
package wdr_pkg;

    localparam int LINE_DEPTH_DEF = 4096;

    localparam int SMP_W   = 24;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;
    localparam int DLY_W   = 28;
    localparam int GAIN_W  = 17;
    localparam int CFG_IDX_W = 2;

    localparam int SMP_MAX = 8388607;
    localparam int SMP_MIN = -8388608;
    localparam int ONE_Q16 = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_MODE   = 2'd3;

    localparam logic [DLY_W-1:0]  DELAY_LENGTH_RST  = 28'd6553600;
    localparam logic [GAIN_W-1:0] DAMPING_COEFF_RST = 17'd65536;
    localparam logic [GAIN_W-1:0] DECAY_GAIN_RST    = 17'd65000;

    typedef logic signed [SMP_W-1:0]  smp_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_LOAD = 2'd1,
        MAC_ADD  = 2'd2
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        smp_t    op_a;
        coef_t   op_b;
    } mac_ctl_t;

endpackage

/* rtl/wdr_mac.sv */
// Shared multiply-accumulate unit with rounding and 24-bit saturation of the rounded output.
module wdr_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  wdr_pkg::mac_ctl_t ctl,
    output wdr_pkg::smp_t     rnd
);
    import wdr_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(SMP_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(SMP_MIN);

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  shifted;

    assign prod = ctl.op_a * ctl.op_b;

    always_comb
    begin
        unique case (ctl.op)
            MAC_LOAD: acc_next = ACC_W'(prod);
            MAC_ADD:  acc_next = acc_reg + ACC_W'(prod);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        biased  = acc_reg + ROUND_BIAS;
        shifted = biased >>> FRAC_W;
        priority if (shifted > SAT_HI)
        begin
            rnd = SAT_HI[SMP_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            rnd = SAT_LO[SMP_W-1:0];
        end
        else
        begin
            rnd = shifted[SMP_W-1:0];
        end
    end

endmodule

/* rtl/wdr_line_mem.sv */
// Delay line memory with one write port and one registered read port.
module wdr_line_mem #(
    parameter int DEPTH  = wdr_pkg::LINE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  wdr_pkg::smp_t     wdata,
    input  logic [ADDR_W-1:0] raddr,
    output wdr_pkg::smp_t     rdata
);
    import wdr_pkg::*;

    smp_t mem [DEPTH];
    smp_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/waveguide_delay_resonator.sv */
// Waveguide resonator top level: configuration registers, sequencer and delay line state.
// A new word is accepted only after the previous one is written back. Between the
// acceptance of a word and a valid out_sample lie one line read, five passes through the shared
// multiplier (the second line read overlaps the first pass) and three rounding steps.
// A result still waiting in the output register holds the last step, so the write-back
// and the next acceptance wait for out_ready. After reset the delay line is cleared
// one entry per cycle, with in_ready low; configuration writes are taken throughout.
// LINE_DEPTH must be a power of two.
module waveguide_delay_resonator #(
    parameter int LINE_DEPTH = wdr_pkg::LINE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wdr_pkg::DLY_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wdr_pkg::smp_t                   excitation,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wdr_pkg::smp_t                   out_sample
);
    import wdr_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int POS_W  = ADDR_W + FRAC_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);
    localparam coef_t ONE_COEF = COEF_W'(ONE_Q16);
    localparam smp_t  SMP_HI = SMP_W'(SMP_MAX);
    localparam smp_t  SMP_LO = SMP_W'(SMP_MIN);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_RD0   = 11'b000_0000_0100,
        ST_RD1   = 11'b000_0000_1000,
        ST_MAC1  = 11'b000_0001_0000,
        ST_RND1  = 11'b000_0010_0000,
        ST_MAC2  = 11'b000_0100_0000,
        ST_MAC3  = 11'b000_1000_0000,
        ST_RND2  = 11'b001_0000_0000,
        ST_MAC4  = 11'b010_0000_0000,
        ST_RND3  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [DLY_W-1:0]  delay_length_reg;
    logic [GAIN_W-1:0] damping_coeff_reg;
    logic [GAIN_W-1:0] decay_gain_reg;
    logic              closed_mode_reg;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] i0_reg, i0_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    smp_t              exc_reg, exc_next;
    smp_t              smp_reg, smp_next;
    smp_t              filt_reg, filt_next;
    logic              out_valid_reg, out_valid_next;
    smp_t              out_sample_reg, out_sample_next;

    logic [31:0]       dly_ext;
    logic [POS_W-1:0]  dly_mod;
    logic [POS_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] i1;
    logic              accept;
    logic              finish;

    mac_ctl_t          mac_ctl;
    smp_t              rnd;
    smp_t              rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    smp_t              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    smp_t              ds_neg;
    logic signed [SMP_W:0] wb_sum;
    smp_t              wb_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg  <= DELAY_LENGTH_RST;
            damping_coeff_reg <= DAMPING_COEFF_RST;
            decay_gain_reg    <= DECAY_GAIN_RST;
            closed_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data;
                REG_DAMPING_COEFF: damping_coeff_reg <= cfg_data[GAIN_W-1:0];
                REG_DECAY_GAIN:    decay_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_CLOSED_MODE:   closed_mode_reg   <= cfg_data[0];
                default:           closed_mode_reg   <= closed_mode_reg;
            endcase
        end
    end

    assign dly_ext = {{(32 - DLY_W){1'b0}}, delay_length_reg};
    assign dly_mod = dly_ext[POS_W-1:0];
    assign rd_pos  = {wp_reg, {FRAC_W{1'b0}}} - dly_mod;
    assign i1      = i0_reg + 1'b1;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == ST_RND3) && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (rnd == SMP_LO)
        begin
            ds_neg = closed_mode_reg ? SMP_HI : rnd;
        end
        else
        begin
            ds_neg = closed_mode_reg ? -rnd : rnd;
        end
        wb_sum = {exc_reg[SMP_W-1], exc_reg} + {ds_neg[SMP_W-1], ds_neg};
        if (wb_sum > $signed({1'b0, SMP_HI}))
        begin
            wb_sat = SMP_HI;
        end
        else if (wb_sum < $signed({1'b1, SMP_LO}))
        begin
            wb_sat = SMP_LO;
        end
        else
        begin
            wb_sat = wb_sum[SMP_W-1:0];
        end
    end

    always_comb
    begin
        mac_ctl.op   = MAC_HOLD;
        mac_ctl.op_a = rdata;
        mac_ctl.op_b = '0;
        unique case (state_reg)
            ST_RD1:
            begin
                mac_ctl.op   = MAC_LOAD;
                mac_ctl.op_a = rdata;
                mac_ctl.op_b = ONE_COEF - $signed({2'b00, frac_reg});
            end
            ST_MAC1:
            begin
                mac_ctl.op   = MAC_ADD;
                mac_ctl.op_a = rdata;
                mac_ctl.op_b = $signed({2'b00, frac_reg});
            end
            ST_MAC2:
            begin
                mac_ctl.op   = MAC_LOAD;
                mac_ctl.op_a = smp_reg;
                mac_ctl.op_b = $signed({1'b0, damping_coeff_reg});
            end
            ST_MAC3:
            begin
                mac_ctl.op   = MAC_ADD;
                mac_ctl.op_a = filt_reg;
                mac_ctl.op_b = ONE_COEF - $signed({1'b0, damping_coeff_reg});
            end
            ST_MAC4:
            begin
                mac_ctl.op   = MAC_LOAD;
                mac_ctl.op_a = smp_reg;
                mac_ctl.op_b = $signed({1'b0, decay_gain_reg});
            end
            default:
            begin
                mac_ctl.op = MAC_HOLD;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        wp_next         = wp_reg;
        i0_next         = i0_reg;
        frac_next       = frac_reg;
        exc_next        = exc_reg;
        smp_next        = smp_reg;
        filt_next       = filt_reg;
        out_sample_next = out_sample_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mem_raddr       = i0_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    i0_next    = rd_pos[POS_W-1:FRAC_W];
                    frac_next  = rd_pos[FRAC_W-1:0];
                    exc_next   = excitation;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:
            begin
                mem_raddr  = i1;
                state_next = ST_MAC1;
            end
            ST_MAC1: state_next = ST_RND1;
            ST_RND1:
            begin
                smp_next   = rnd;
                state_next = ST_MAC2;
            end
            ST_MAC2: state_next = ST_MAC3;
            ST_MAC3: state_next = ST_RND2;
            ST_RND2:
            begin
                smp_next   = rnd;
                filt_next  = rnd;
                state_next = ST_MAC4;
            end
            ST_MAC4: state_next = ST_RND3;
            ST_RND3:
            begin
                if (finish)
                begin
                    out_sample_next = ds_neg;
                    out_valid_next  = 1'b1;
                    wp_next         = wp_reg + 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign mem_we    = (state_reg == ST_CLEAR) || finish;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : wp_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : wb_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            filt_reg      <= filt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i0_reg         <= i0_next;
        frac_reg       <= frac_next;
        exc_reg        <= exc_next;
        smp_reg        <= smp_next;
        out_sample_reg <= out_sample_next;
    end

    wdr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .rnd   (rnd)
    );

    wdr_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_RD0)
        else $error("Accepted word did not start a line read.");

    a_write_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != ST_CLEAR) |-> state_reg == ST_RND3)
        else $error("Delay line written outside the write-back step.");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RND3))
        else $error("Result word raised outside the write-back step.");

    a_wp_advances: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> wp_reg == ADDR_W'($past(wp_reg) + 1'b1))
        else $error("Write position did not advance by one.");

endmodule

/* dv/tb_waveguide_delay_resonator.sv */
// Self-checking testbench for the waveguide delay resonator with a built-in loop predictor.
module tb_waveguide_delay_resonator;
    import wdr_pkg::*;

    localparam int DEPTH = LINE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DLY_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    smp_t                 excitation;
    logic                 out_valid;
    logic                 out_ready;
    smp_t                 out_sample;

    smp_t              line_mem [DEPTH];
    logic [11:0]       wr_ptr;
    smp_t              lp_prev;
    logic [DLY_W-1:0]  dly_len;
    logic [GAIN_W-1:0] damp;
    logic [GAIN_W-1:0] gain;
    logic              closed;

    smp_t loop_out_q [$];
    smp_t want;
    int   mismatches;
    bit   tx_idling;
    bit   rx_idling;
    bit   hold_request;

    waveguide_delay_resonator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .excitation (excitation),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic smp_t clamp24(longint v);
        if (v > SMP_MAX)
            return smp_t'(SMP_MAX);
        if (v < SMP_MIN)
            return smp_t'(SMP_MIN);
        return smp_t'(v);
    endfunction

    function automatic longint round16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic smp_t advance_loop(smp_t x);
        logic [DLY_W-1:0] rpos;
        logic [11:0]      i0;
        logic [11:0]      i1;
        longint           fr;
        longint           r;
        smp_t             tap;
        smp_t             y;
        smp_t             fb;
        rpos = {wr_ptr, 16'h0000} - dly_len;
        i0 = rpos[27:16];
        i1 = i0 + 12'd1;
        fr = longint'(rpos[15:0]);
        r = longint'(damp);
        tap = clamp24(round16(longint'(line_mem[i0]) * (ONE_Q16 - fr)
                              + longint'(line_mem[i1]) * fr));
        y = clamp24(round16(r * longint'(tap) + (ONE_Q16 - r) * longint'(lp_prev)));
        lp_prev = y;
        fb = clamp24(round16(longint'(y) * longint'(gain)));
        if (closed)
            fb = clamp24(-longint'(fb));
        line_mem[wr_ptr] = clamp24(longint'(x) + longint'(fb));
        wr_ptr = wr_ptr + 12'd1;
        return fb;
    endfunction

    function automatic smp_t pick_excitation();
        smp_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = '0;
            5, 6: v = smp_t'($urandom());
            7: v = $urandom_range(0, 1) ? smp_t'(SMP_MAX) : smp_t'(SMP_MIN);
            default: v = smp_t'(int'($urandom_range(0, 4000)) - 2000);
        endcase
        return v;
    endfunction

    function automatic logic [DLY_W-1:0] pick_delay();
        logic [DLY_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = DLY_W'($urandom_range(0, 65535));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = DLY_W'(65536);
                    2: v = DLY_W'(268369920);
                    default: v = '1;
                endcase
            end
            2: v = DLY_W'($urandom());
            default: v = DLY_W'($urandom_range(65536, 300 * 65536));
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(int unsigned lo);
        logic [GAIN_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = GAIN_W'(ONE_Q16);
            2: v = GAIN_W'($urandom_range(ONE_Q16 + 1, 131071));
            default: v = GAIN_W'($urandom_range(lo, ONE_Q16));
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            REG_DELAY_LENGTH: dly_len = val;
            REG_DAMPING_COEFF: damp = val[GAIN_W-1:0];
            REG_DECAY_GAIN: gain = val[GAIN_W-1:0];
            default: closed = val[0];
        endcase
    endtask

    task automatic load_voice(input logic [DLY_W-1:0] dl, input logic [GAIN_W-1:0] dc,
                              input logic [GAIN_W-1:0] dg, input logic cm);
        write_reg(REG_DELAY_LENGTH, dl);
        write_reg(REG_DAMPING_COEFF, DLY_W'(dc));
        write_reg(REG_DECAY_GAIN, DLY_W'(dg));
        write_reg(REG_CLOSED_MODE, DLY_W'(cm));
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input smp_t x);
        in_valid <= 1'b1;
        excitation <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        loop_out_q.push_back(advance_loop(x));
        @(negedge clk);
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (loop_out_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_words(input int n);
        repeat (n) send_word(pick_excitation());
        drain();
    endtask

    task automatic test_reset_state();
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(SMP_MIN));
        send_word('0);
        send_word(smp_t'(1));
        send_word(smp_t'(-1));
        send_word(smp_t'(24'h555555));
        drain();
    endtask

    task automatic test_sub_sample_delay();
        load_voice('0, GAIN_W'(ONE_Q16), GAIN_W'(ONE_Q16), 1'b0);
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(24'hAAAAAA));
        drain();
        load_voice(DLY_W'(32768), GAIN_W'(ONE_Q16), GAIN_W'(ONE_Q16), 1'b0);
        send_word(smp_t'(4000000));
        send_word('0);
        drain();
        load_voice(DLY_W'(65536), GAIN_W'(ONE_Q16), GAIN_W'(ONE_Q16), 1'b0);
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(SMP_MAX));
        drain();
    endtask

    task automatic test_closed_negation();
        load_voice(DLY_W'(65536), GAIN_W'(ONE_Q16), GAIN_W'(ONE_Q16), 1'b1);
        send_word(smp_t'(SMP_MIN));
        send_word('0);
        send_word('0);
        drain();
    endtask

    task automatic test_coeff_over_one();
        load_voice(DLY_W'(163840), GAIN_W'(131071), GAIN_W'(131071), 1'b0);
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(SMP_MAX));
        send_word(smp_t'(SMP_MIN));
        drain();
    endtask

    task automatic test_delay_wrap();
        load_voice('1, '0, '0, 1'b0);
        send_word(smp_t'(SMP_MIN));
        send_word(smp_t'(123456));
        drain();
        load_voice(DLY_W'(268369920), GAIN_W'(ONE_Q16), GAIN_W'(ONE_Q16), 1'b1);
        send_word(smp_t'(-7654321));
        send_word(smp_t'(SMP_MAX));
        drain();
    endtask

    task automatic test_random_sweep();
        repeat (20)
        begin
            rx_idling = ($urandom_range(0, 3) != 0);
            tx_idling = ($urandom_range(0, 3) != 0);
            load_voice(pick_delay(), pick_gain(0), pick_gain(50000), 1'($urandom()));
            run_words(65);
        end
        rx_idling = 1'b1;
        tx_idling = 1'b1;
    endtask

    task automatic test_output_stall();
        load_voice(DLY_W'($urandom_range(65536, 40 * 65536)), pick_gain(0), pick_gain(50000),
                   1'($urandom()));
        tx_idling = 1'b0;
        hold_request = 1'b1;
        run_words(40);
        tx_idling = 1'b1;
    endtask

    task automatic test_full_rate();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (2)
        begin
            load_voice(pick_delay(), pick_gain(0), pick_gain(50000), 1'($urandom()));
            run_words(150);
        end
    endtask

    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && rx_idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (loop_out_q.size() == 0)
            begin
                $display("%0t: out_sample expected none, got %0d", $time, out_sample);
                mismatches++;
            end
            else
            begin
                want = loop_out_q.pop_front();
                if (out_sample !== want)
                begin
                    $display("%0t: out_sample expected %0d, got %0d", $time, want, out_sample);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        excitation = '0;
        mismatches = 0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        hold_request = 1'b0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        wr_ptr = '0;
        lp_prev = '0;
        dly_len = DELAY_LENGTH_RST;
        damp = DAMPING_COEFF_RST;
        gain = DECAY_GAIN_RST;
        closed = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_sub_sample_delay();
        test_closed_negation();
        test_coeff_over_one();
        test_delay_wrap();
        test_random_sweep();
        test_output_stall();
        test_full_rate();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
